// ===== hdl/bbvn_pkg.sv =====
// ============================================================================
// bbvn_pkg: shared constants and types of the bounding box normalizer
// Field widths, fixed-point constants and the lane control bundle.
// ============================================================================
package bbvn_pkg;

    // parameter defaults
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_WIDTH_DEF  = 32;

    // stream field widths
    localparam int AXIS_W   = 32;
    localparam int NUM_AXES = 3;

    // (2v - mn - mx) * 2^29 / E gives Q2.30; the quotient fits 30 bits
    localparam int FRAC_SHIFT = 29;
    localparam int QUO_W      = 30;

    // per-cycle commands from the sequencer to every lane
    typedef struct packed {
        logic wr_en;      // store a vertex coordinate and update min/max
        logic clr;        // reset the box for the next mesh
        logic fin;        // latch extent and min+max
        logic rd_en;      // read a stored coordinate
        logic num_en;     // form |2v - mn - mx| and its sign
        logic div_start;  // start the divider
    } t_lane_ctrl;

endpackage

// ===== hdl/bbvn_lane.sv =====
// ============================================================================
// bbvn_lane: one axis of the normalizer
// Coordinate store, min/max tracking and a bit-serial restoring divider.
// ============================================================================
module bbvn_lane #(
    parameter int MAX_VERTICES = bbvn_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = bbvn_pkg::COORD_WIDTH_DEF,
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bbvn_pkg::t_lane_ctrl       i_ctrl,
    input  logic [AW-1:0]              i_addr,
    input  logic [bbvn_pkg::AXIS_W-1:0] i_coord,
    input  logic [COORD_WIDTH-1:0]     i_ext,
    output logic [COORD_WIDTH-1:0]     o_ext,
    output logic                       o_done,
    output logic [bbvn_pkg::AXIS_W-1:0] o_q
);

    localparam int CW   = COORD_WIDTH;
    localparam int QW   = bbvn_pkg::QUO_W;
    localparam int DW   = CW + QW;
    localparam int CNTW = $clog2(QW + 1);

    localparam logic signed [CW-1:0] MOST_POS = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MOST_NEG = {1'b1, {(CW-1){1'b0}}};

    logic signed [CW-1:0] w_coord;
    assign w_coord = $signed(i_coord[CW-1:0]);

    // coordinate store
    logic [CW-1:0] r_mem [MAX_VERTICES];
    logic [CW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_addr] <= w_coord;
        end
        if (i_ctrl.rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    // per-axis min/max
    logic signed [CW-1:0] r_min, r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            r_min <= MOST_POS;
            r_max <= MOST_NEG;
        end else if (i_ctrl.wr_en) begin
            if (w_coord < r_min) r_min <= w_coord;
            if (w_coord > r_max) r_max <= w_coord;
        end
    end

    // extent and min+max at end of mesh
    logic [CW-1:0]        r_ext;
    logic signed [CW:0]   r_sum;
    logic [CW:0]          w_diff;

    assign w_diff = {r_max[CW-1], r_max} - {r_min[CW-1], r_min};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fin) begin
            r_ext <= w_diff[CW-1:0];
            r_sum <= {r_min[CW-1], r_min} + {r_max[CW-1], r_max};
        end
    end

    assign o_ext = r_ext;

    // numerator magnitude and sign; |2v - mn - mx| never exceeds the extent
    logic [CW+1:0] w_dpos, w_dneg;
    logic [CW-1:0] r_mag;
    logic          r_neg;

    assign w_dpos = {r_rd[CW-1], r_rd, 1'b0} - {r_sum[CW], r_sum};
    assign w_dneg = {r_sum[CW], r_sum} - {r_rd[CW-1], r_rd, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.num_en) begin
            r_neg <= w_dpos[CW+1];
            r_mag <= w_dpos[CW+1] ? w_dneg[CW-1:0] : w_dpos[CW-1:0];
        end
    end

    // rounded dividend: mag * 2^29 + E/2
    logic [DW-1:0] w_dvd;
    assign w_dvd = DW'({r_mag, {bbvn_pkg::FRAC_SHIFT{1'b0}}}) + DW'(i_ext >> 1);

    // restoring divider, one quotient bit per cycle; the top part of the
    // dividend is already below E because the quotient fits QW bits
    logic [CW-1:0]   r_rem;
    logic [QW-1:0]   r_sh;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy, r_fix, r_done;
    logic [bbvn_pkg::AXIS_W-1:0] r_q;
    logic [CW:0]     w_trial, w_sub;
    logic            w_ge;

    assign w_trial = {r_rem, r_sh[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, i_ext});
    assign w_sub   = w_trial - {1'b0, i_ext};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_start) begin
            r_rem <= w_dvd[DW-1:QW];
            r_sh  <= w_dvd[QW-1:0];
            r_cnt <= CNTW'(QW);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[CW-1:0] : w_trial[CW-1:0];
            r_sh  <= {r_sh[QW-2:0], w_ge};
            r_cnt <= r_cnt - CNTW'(1);
        end
        if (r_fix) begin
            r_q <= r_neg ? -bbvn_pkg::AXIS_W'(r_sh) : bbvn_pkg::AXIS_W'(r_sh);
        end
    end

    // divider control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_ctrl.div_start) begin
            r_busy <= 1'b1;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_fix <= 1'b0;
            if (r_busy && r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_fix  <= 1'b1;
            end
            if (r_fix) begin
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// ===== hdl/bbvn_merge.sv =====
// ============================================================================
// bbvn_merge: result merge and output register
// Packs the three lane quotients into one result transaction.
// ============================================================================
module bbvn_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [bbvn_pkg::AXIS_W-1:0]   i_q [bbvn_pkg::NUM_AXES],
    input  logic                          i_degen,
    input  logic                          i_last,
    output logic                          o_free,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [bbvn_pkg::NUM_AXES*bbvn_pkg::AXIS_W-1:0] o_m_tdata,
    output logic                          o_m_tlast,
    output logic                          o_m_tuser
);

    localparam int W = bbvn_pkg::AXIS_W;

    logic                                    r_valid;
    logic [bbvn_pkg::NUM_AXES*W-1:0]         r_data;
    logic                                    r_last, r_degen;

    // a new result may enter when the register is empty or being drained
    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // zero extent forces zero outputs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int a = 0; a < bbvn_pkg::NUM_AXES; a++) begin
                r_data[a*W +: W] <= i_degen ? '0 : i_q[a];
            end
            r_last  <= i_last;
            r_degen <= i_degen;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_degen;

endmodule

// ===== hdl/bounding_box_vertex_normalizer.sv =====
// ============================================================================
// bounding_box_vertex_normalizer: mesh bounding box and unit-cube scaling
// Stores a mesh's vertices, then emits them recentered and scaled by the
// largest box extent as signed Q2.30 values.
// ============================================================================
// Usage:
//   Slave stream carries vertices (Q16.16 x, y, z); tlast marks the last
//   vertex of a mesh. Vertices beyond MAX_VERTICES are dropped, but their
//   tlast still ends the mesh.
//   While loading, one vertex transaction is taken every cycle.
//   After tlast, states S_FIN and S_EXT find the box extent, then each stored
//   vertex is emitted on the master stream in arrival order. Each result goes
//   through S_READ, S_NUM, S_START and S_WAIT before the next; the three per-axis
//   dividers produce one quotient bit per cycle. The master tlast marks the last
//   result of the mesh; tuser is 1 when the extent is zero and all outputs are zero.
//   The slave side is not ready while results are being computed; it is
//   ready again as soon as the last result sits in the output register.
//   A stalled master side holds the output register and the next result
//   waits in the lanes.
//   Reset empties the box and the output register; the vertex stores are
//   not cleared, so there is no startup sweep.
// ============================================================================
module bounding_box_vertex_normalizer #(
    parameter int MAX_VERTICES = bbvn_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = bbvn_pkg::COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64]
    input  logic        s_axis_tlast,   // end_of_mesh
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // norm_x[31:0], norm_y[63:32], norm_z[95:64]
    output logic        m_axis_tlast,   // final_vertex
    output logic        m_axis_tuser    // degenerate
);

    localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int CW   = COORD_WIDTH;
    localparam int W    = bbvn_pkg::AXIS_W;
    localparam int NA   = bbvn_pkg::NUM_AXES;

    typedef enum logic [2:0] {
        S_LOAD, S_FIN, S_EXT, S_READ, S_NUM, S_START, S_WAIT
    } t_state;

    t_state          r_state;
    logic [CNTW-1:0] r_count;
    logic [AW-1:0]   r_idx;
    logic [CW-1:0]   r_ext;
    logic            r_degen;

    bbvn_pkg::t_lane_ctrl w_ctrl;
    logic [AW-1:0]   w_addr;
    logic [CW-1:0]   w_ext [NA];
    logic [CW-1:0]   w_ext_max;
    logic [NA-1:0]   w_done;
    logic [W-1:0]    w_q [NA];
    logic            w_free, w_push, w_last, w_accept, w_room;

    assign s_axis_tready = (r_state == S_LOAD);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_room        = (r_count < CNTW'(MAX_VERTICES));
    assign w_last        = ((CNTW'(r_idx) + CNTW'(1)) == r_count);
    assign w_push        = (r_state == S_WAIT) && (&w_done) && w_free;
    assign w_addr        = (r_state == S_LOAD) ? r_count[AW-1:0] : r_idx;

    // lane commands
    always_comb begin
        w_ctrl.wr_en     = w_accept && w_room;
        w_ctrl.clr       = ((r_state == S_FIN) && (r_count == '0)) || (w_push && w_last);
        w_ctrl.fin       = (r_state == S_FIN) && (r_count != '0);
        w_ctrl.rd_en     = (r_state == S_READ);
        w_ctrl.num_en    = (r_state == S_NUM);
        w_ctrl.div_start = (r_state == S_START);
    end

    // largest extent over the axes
    always_comb begin
        w_ext_max = w_ext[0];
        for (int a = 1; a < NA; a++) begin
            if (w_ext[a] > w_ext_max) w_ext_max = w_ext[a];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_idx   <= '0;
            r_ext   <= '0;
            r_degen <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) r_count <= r_count + CNTW'(1);
                        if (s_axis_tlast) r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= (r_count == '0) ? S_LOAD : S_EXT;
                end
                S_EXT: begin
                    r_ext   <= w_ext_max;
                    r_degen <= (w_ext_max == '0);
                    r_idx   <= '0;
                    r_state <= S_READ;
                end
                S_READ:  r_state <= S_NUM;
                S_NUM:   r_state <= S_START;
                S_START: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_push) begin
                        if (w_last) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // one lane per axis
    for (genvar a = 0; a < NA; a++) begin : g_lane
        bbvn_lane #(
            .MAX_VERTICES (MAX_VERTICES),
            .COORD_WIDTH  (COORD_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_addr  (w_addr),
            .i_coord (s_axis_tdata[a*W +: W]),
            .i_ext   (r_ext),
            .o_ext   (w_ext[a]),
            .o_done  (w_done[a]),
            .o_q     (w_q[a])
        );
    end

    bbvn_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_q        (w_q),
        .i_degen    (r_degen),
        .i_last     (w_last),
        .o_free     (w_free),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

// ===== hdl/bbvn_checker.sv =====
// ============================================================================
// bbvn_checker: port-level checks of the bounding box normalizer
// Watches the result stream and the input handshake over time.
// ============================================================================
module bbvn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    localparam logic signed [31:0] LIM_POS = 32'sd536870912;
    localparam logic signed [31:0] LIM_NEG = -32'sd536870912;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // zero extent gives zero outputs
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate result not zero");

    // no new vertices while a mesh is still being emitted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during mesh output");

    // every normalized value lies within -0.5 .. +0.5
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[31:0]) <= LIM_POS && $signed(m_axis_tdata[31:0]) >= LIM_NEG
            && $signed(m_axis_tdata[63:32]) <= LIM_POS
            && $signed(m_axis_tdata[63:32]) >= LIM_NEG
            && $signed(m_axis_tdata[95:64]) <= LIM_POS
            && $signed(m_axis_tdata[95:64]) >= LIM_NEG)
        else $error("normalized value out of range");

endmodule

bind bounding_box_vertex_normalizer bbvn_checker u_bbvn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top: self-checking bench for bounding_box_vertex_normalizer
// Streams meshes of Q16.16 vertices into the block and predicts every
// recentered, unit-cube Q2.30 result. Each result from the master stream is
// compared against the oldest prediction.
// Coverage: extremes, degenerate boxes, rounding ties, store overflow and
// random meshes. Both stream sides idle at random, with one long hold-off.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     AXIS_W        = bbvn_pkg::AXIS_W;
    localparam int     NUM_AXES      = bbvn_pkg::NUM_AXES;
    localparam int     FRAC_SHIFT    = bbvn_pkg::FRAC_SHIFT;
    localparam int     MAX_VERTS     = bbvn_pkg::MAX_VERTICES_DEF;
    localparam longint COORD_MAX     = 64'sd2147483647;
    localparam longint COORD_MIN     = -64'sd2147483648;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     SETTLE_CYCLES = 120;
    localparam int     TOTAL_ITEMS   = 400;
    localparam int     QUIET_ITEMS   = 60;

    localparam logic [AXIS_W-1:0] C_MIN    = 32'h8000_0000;
    localparam logic [AXIS_W-1:0] C_MAX    = 32'h7FFF_FFFF;
    localparam logic [AXIS_W-1:0] C_NEG1   = 32'hFFFF_FFFF;
    localparam logic [AXIS_W-1:0] HALF_POS = 32'h4000_0000;  // +2^30
    localparam logic [AXIS_W-1:0] HALF_NEG = 32'hC000_0000;  // -2^30

    // how the coordinates of a random mesh are drawn
    typedef enum int {
        STYLE_FULL,     // any 32-bit value
        STYLE_NARROW,   // cluster just above a random base, some axes flat
        STYLE_FLAT,     // every vertex identical
        STYLE_EXTREME   // mostly min, max, 0 and -1
    } t_mesh_style;

    typedef struct {
        logic [AXIS_W-1:0] nx;
        logic [AXIS_W-1:0] ny;
        logic [AXIS_W-1:0] nz;
        logic              fin;
        logic              degen;
    } t_norm_vertex;

    // Mesh store, bounding box and the queue of normalized vertices due
    class unit_cube_scoreboard;
        logic signed [AXIS_W-1:0] vx[MAX_VERTS];
        logic signed [AXIS_W-1:0] vy[MAX_VERTS];
        logic signed [AXIS_W-1:0] vz[MAX_VERTS];
        longint                   box_lo[NUM_AXES];
        longint                   box_hi[NUM_AXES];
        int unsigned              count;
        t_norm_vertex             expected_q[$];
        int                       errors;
        int                       checked;
        int                       meshes;
        int                       flat_meshes;
        int                       dropped;
        int                       vertices;

        function new();
            errors      = 0;
            checked     = 0;
            meshes      = 0;
            flat_meshes = 0;
            dropped     = 0;
            vertices    = 0;
            clear_box();
        endfunction

        function void clear_box();
            for (int a = 0; a < NUM_AXES; a++) begin
                box_lo[a] = COORD_MAX;
                box_hi[a] = COORD_MIN;
            end
            count = 0;
        endfunction

        // (2v - lo - hi) * 2^29 / ext, rounded half away from zero
        function logic [AXIS_W-1:0] scale_coord(longint v, int a, bit [63:0] ext);
            longint    num;
            bit [63:0] mag;
            bit [63:0] quo;
            num = 2 * v - box_lo[a] - box_hi[a];
            mag = (num < 0) ? 64'(-num) : 64'(num);
            quo = ((mag << FRAC_SHIFT) + (ext >> 1)) / ext;
            if (num < 0)
                quo = -quo;
            return quo[AXIS_W-1:0];
        endfunction

        function void note_vertex(logic signed [AXIS_W-1:0] px,
                                  logic signed [AXIS_W-1:0] py,
                                  logic signed [AXIS_W-1:0] pz,
                                  logic last);
            longint       p[NUM_AXES];
            bit [63:0]    ext;
            bit [63:0]    span;
            t_norm_vertex r;
            p[0] = px;
            p[1] = py;
            p[2] = pz;
            vertices++;
            // a full store drops the vertex, but tlast still counts
            if (count < MAX_VERTS) begin
                vx[count] = px;
                vy[count] = py;
                vz[count] = pz;
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (p[a] < box_lo[a]) box_lo[a] = p[a];
                    if (p[a] > box_hi[a]) box_hi[a] = p[a];
                end
                count++;
            end else begin
                dropped++;
            end
            if (last !== 1'b1)
                return;

            ext = 0;
            if (count > 0) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    span = box_hi[a] - box_lo[a];
                    if (span > ext) ext = span;
                end
            end
            meshes++;
            if (ext == 0) flat_meshes++;
            for (int i = 0; i < count; i++) begin
                if (ext == 0) begin
                    r.nx = '0;
                    r.ny = '0;
                    r.nz = '0;
                end else begin
                    r.nx = scale_coord(vx[i], 0, ext);
                    r.ny = scale_coord(vy[i], 1, ext);
                    r.nz = scale_coord(vz[i], 2, ext);
                end
                r.fin   = (i + 1 == count);
                r.degen = (ext == 0);
                expected_q.push_back(r);
            end
            clear_box();
        endfunction

        function void check_result(logic [NUM_AXES*AXIS_W-1:0] data, logic fin,
                                   logic degen);
            t_norm_vertex want;
            t_norm_vertex got;
            got.nx    = data[AXIS_W-1:0];
            got.ny    = data[2*AXIS_W-1:AXIS_W];
            got.nz    = data[3*AXIS_W-1:2*AXIS_W];
            got.fin   = fin;
            got.degen = degen;
            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result x=%h y=%h z=%h last=%b degen=%b",
                         $time, got.nx, got.ny, got.nz, got.fin, got.degen);
                return;
            end
            want = expected_q.pop_front();
            if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                got.fin !== want.fin || got.degen !== want.degen) begin
                errors++;
                $display("%0t: mismatch expected x=%h y=%h z=%h last=%b degen=%b",
                         $time, want.nx, want.ny, want.nz, want.fin, want.degen);
                $display("%0t:          actual   x=%h y=%h z=%h last=%b degen=%b",
                         $time, got.nx, got.ny, got.nz, got.fin, got.degen);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata  = '0;    // pos_x[31:0], pos_y[63:32], pos_z[95:64]
    logic        s_axis_tlast  = 1'b0;  // end_of_mesh
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;          // norm_x[31:0], norm_y[63:32], norm_z[95:64]
    logic        m_axis_tlast;          // final_vertex
    logic        m_axis_tuser;          // degenerate

    unit_cube_scoreboard sb;
    int  items_sent  = 0;
    int  cycle_count = 0;
    bit  quiet       = 1'b0;   // no idling on either side
    bit  hold_req    = 1'b0;   // receiver long hold-off request
    int  holds_done  = 0;

    bounding_box_vertex_normalizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // one vertex transaction; returns just after the accepting edge
    task automatic send_vertex(input logic [AXIS_W-1:0] px, input logic [AXIS_W-1:0] py,
                               input logic [AXIS_W-1:0] pz, input logic last);
        s_axis_tdata  <= {pz, py, px};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_vertex(px, py, pz, last);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // idle the sender until every predicted result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_mesh(input int n_verts, input t_mesh_style style, input bit gappy);
        logic [AXIS_W-1:0] base[NUM_AXES];
        logic [AXIS_W-1:0] c[NUM_AXES];
        int unsigned       spread[NUM_AXES];
        for (int a = 0; a < NUM_AXES; a++) begin
            base[a]   = $urandom;
            spread[a] = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(0, 24));
        end
        for (int i = 0; i < n_verts; i++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                case (style)
                    STYLE_FULL:   c[a] = $urandom;
                    STYLE_NARROW: c[a] = base[a] + $urandom_range(0, spread[a]);
                    STYLE_FLAT:   c[a] = base[a];
                    default: begin
                        case ($urandom_range(0, 4))
                            0:       c[a] = C_MIN;
                            1:       c[a] = C_MAX;
                            2:       c[a] = '0;
                            3:       c[a] = C_NEG1;
                            default: c[a] = $urandom;
                        endcase
                    end
                endcase
            end
            send_vertex(c[0], c[1], c[2], i == n_verts - 1);
            if (gappy && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 10));
        end
    endtask

    // stimulus and final verdict
    initial begin
        int          mesh_idx;
        int          size;
        t_mesh_style style;
        bit          gappy;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-vertex meshes are always degenerate
        send_vertex('0, '0, '0, 1'b1);
        send_vertex(C_MIN, C_MAX, C_NEG1, 1'b1);
        // identical vertices: zero extent
        send_vertex(32'h0001_8000, C_NEG1, C_MAX, 1'b0);
        send_vertex(32'h0001_8000, C_NEG1, C_MAX, 1'b0);
        send_vertex(32'h0001_8000, C_NEG1, C_MAX, 1'b1);
        // full-range box on every axis
        send_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MAX, C_MAX, 1'b1);
        // only z spans the box
        send_vertex(32'd5, 32'd7, -32'sd3, 1'b0);
        send_vertex(32'd5, 32'd7, 32'd100, 1'b0);
        send_vertex(32'd5, 32'd7, 32'd40, 1'b1);
        // extent 2^31 on x puts exact halves on both signs: ties round away
        send_vertex(HALF_NEG, '0, '0, 1'b0);
        send_vertex(HALF_POS, '0, '0, 1'b0);
        send_vertex(32'd1, '0, '0, 1'b0);
        send_vertex(HALF_NEG + 32'd1, '0, '0, 1'b1);
        // mixed extremes across axes
        send_vertex(C_MAX, C_NEG1, '0, 1'b0);
        send_vertex(C_MIN, 32'd1, 32'h7FFF_0000, 1'b1);
        wait_drained();

        // receiver held off while meshes keep coming: input side must stall
        hold_req = 1'b1;
        send_mesh(5, STYLE_FULL, 1'b0);
        send_mesh(3, STYLE_NARROW, 1'b0);
        send_mesh(2, STYLE_EXTREME, 1'b0);
        wait_drained();

        // random meshes, mostly small, now and then one past the store depth
        mesh_idx = 0;
        while (items_sent < TOTAL_ITEMS) begin
            quiet = (items_sent >= TOTAL_ITEMS - QUIET_ITEMS);
            if (mesh_idx % 20 == 2) begin
                size = $urandom_range(MAX_VERTS + 1, MAX_VERTS + 6);
            end else begin
                case ($urandom_range(0, 9))
                    7, 8:    size = $urandom_range(9, 32);
                    9:       size = $urandom_range(33, MAX_VERTS);
                    default: size = $urandom_range(1, 8);
                endcase
            end
            case ($urandom_range(0, 9))
                4, 5, 6: style = STYLE_NARROW;
                7:       style = STYLE_FLAT;
                8, 9:    style = STYLE_EXTREME;
                default: style = STYLE_FULL;
            endcase
            gappy = !quiet && ($urandom_range(0, 2) != 0);
            send_mesh(size, style, gappy);
            if (!quiet && $urandom_range(0, 7) == 0)
                wait_drained();
            else if (gappy && $urandom_range(0, 1) == 0)
                pause_sender($urandom_range(1, 10));
            mesh_idx++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d meshes (%0d with zero extent), %0d vertices sent,",
                 sb.meshes, sb.flat_meshes, sb.vertices);
        $display("%0d dropped on a full store, %0d results checked, %0d hold-offs, %0d errors",
                 sb.dropped, sb.checked, holds_done, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bbvn_pkg.sv
hdl/bbvn_lane.sv
hdl/bbvn_merge.sv
hdl/bounding_box_vertex_normalizer.sv
hdl/bbvn_checker.sv
sim/tb_top.sv
